// ----- sv/prdc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the packet receive deframer and channel router.
// Used by every module of the block; depends on nothing.
package prdc_pkg;

    localparam int SLOTS_DEF = 4;

    localparam int CFG_ADDR_W = 4;
    localparam logic [7:0] LEN_OVERHEAD = 8'd3;

    typedef enum logic [1:0] {
        REG_REPLY_TYPE = 2'd0,
        REG_WRITE_TYPE = 2'd1,
        REG_EOF_TYPE   = 2'd2,
        REG_CAPACITY   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        KIND_START = 3'd0,
        KIND_DATA  = 3'd1,
        KIND_DRAIN = 3'd2,
        KIND_REG   = 3'd3,
        KIND_FULL  = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0] reply_type;
        logic [7:0] write_type;
        logic [7:0] eof_type;
        logic [7:0] capacity;
    } t_cfg;

    typedef struct packed {
        logic alloc;
        logic free;
    } t_tbl_req;

    typedef struct packed {
        logic free_found;
        logic hit;
    } t_tbl_rsp;

    typedef struct packed {
        logic       error;
        logic       done_res;
        logic [7:0] data_byte;
        logic [7:0] content_length;
        logic [7:0] frame_type;
        logic [7:0] channel;
        logic [1:0] slot;
        t_kind      kind;
    } t_result;

endpackage

// ----- sv/packet_rx_deframer_channel_router.sv -----
`timescale 1ns / 1ps
// Receive deframer and channel router: parses framed bytes, routes them by channel.
// Throughput is one word per cycle; the result register refills while it is being
// taken, and a result word left waiting on the master side stalls the input side.
// Synchronous active-low reset empties the channel table, returns the parser to waiting
// for a type byte and loads the configuration registers with their defaults.
// Depends on prdc_pkg, prdc_apb_regs, prdc_chan_table and prdc_deframer.
module packet_rx_deframer_channel_router #(
    parameter int SLOTS = prdc_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] rx_byte, [14:8] channel_id, [15] zero
    input  logic [15:0]                     i_s_tdata,
    // [0] command
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [1:0] slot, [9:2] channel, [17:10] frame_type, [25:18] content_length,
    // [33:26] data_byte, [39:34] zero
    output logic [39:0]                     o_m_tdata,
    // [2:0] kind, [3] error
    output logic [3:0]                      o_m_tuser,
    // done_res
    output logic                            o_m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    prdc_pkg::t_cfg     w_cfg;
    prdc_pkg::t_tbl_req w_req;
    prdc_pkg::t_tbl_rsp w_rsp;
    prdc_pkg::t_result  w_result;
    logic [SW-1:0]      w_alloc_slot;
    logic [SW-1:0]      w_hit_slot;
    logic [SW-1:0]      w_free_slot;
    logic               w_accept;
    logic               w_out_valid;

    assign o_s_tready = !w_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {6'd0, w_result.data_byte, w_result.content_length,
                         w_result.frame_type, w_result.channel, w_result.slot};
    assign o_m_tuser  = {w_result.error, w_result.kind};
    assign o_m_tlast  = w_result.done_res;

    prdc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    prdc_chan_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .i_cid         (i_s_tdata[14:8]),
        .i_free_slot   (w_free_slot),
        .i_lookup_byte (i_s_tdata[7:0]),
        .o_rsp         (w_rsp),
        .o_alloc_slot  (w_alloc_slot),
        .o_hit_slot    (w_hit_slot)
    );

    prdc_deframer #(
        .SLOTS (SLOTS)
    ) u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (i_s_tuser),
        .i_rx_byte    (i_s_tdata[7:0]),
        .i_cid        (i_s_tdata[14:8]),
        .i_cfg        (w_cfg),
        .i_rsp        (w_rsp),
        .i_alloc_slot (w_alloc_slot),
        .i_hit_slot   (w_hit_slot),
        .o_req        (w_req),
        .o_free_slot  (w_free_slot),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (w_out_valid),
        .o_result     (w_result)
    );

endmodule

// ----- sv/prdc_apb_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file behind an APB-style port.
// Depends on prdc_pkg for the register indexes and the configuration struct.
module prdc_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prdc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output prdc_pkg::t_cfg                  o_cfg
);

    prdc_pkg::t_cfg r_cfg;
    prdc_pkg::t_reg_idx w_idx;
    logic [7:0] w_rdata;

    assign w_idx  = prdc_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;
    assign prdata = {24'd0, w_rdata};

    always_comb begin
        unique case (w_idx)
            prdc_pkg::REG_REPLY_TYPE: w_rdata = r_cfg.reply_type;
            prdc_pkg::REG_WRITE_TYPE: w_rdata = r_cfg.write_type;
            prdc_pkg::REG_EOF_TYPE:   w_rdata = r_cfg.eof_type;
            prdc_pkg::REG_CAPACITY:   w_rdata = r_cfg.capacity;
            default:                  w_rdata = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_type <= 8'd1;
            r_cfg.write_type <= 8'd2;
            r_cfg.eof_type   <= 8'd3;
            r_cfg.capacity   <= 8'd252;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                prdc_pkg::REG_REPLY_TYPE: r_cfg.reply_type <= pwdata[7:0];
                prdc_pkg::REG_WRITE_TYPE: r_cfg.write_type <= pwdata[7:0];
                prdc_pkg::REG_EOF_TYPE:   r_cfg.eof_type   <= pwdata[7:0];
                prdc_pkg::REG_CAPACITY:   r_cfg.capacity   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/prdc_chan_table.sv -----
`timescale 1ns / 1ps
// Channel table: valid bits and channel numbers, lowest-free allocation and lookup.
// Depends on prdc_pkg for the request and response structs.
module prdc_chan_table #(
    parameter int SLOTS = prdc_pkg::SLOTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  prdc_pkg::t_tbl_req                     i_req,
    input  logic [6:0]                             i_cid,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_free_slot,
    input  logic [7:0]                             i_lookup_byte,
    output prdc_pkg::t_tbl_rsp                     o_rsp,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_alloc_slot,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_hit_slot
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] r_valid;
    logic [6:0]       r_chan [SLOTS];

    always_comb begin
        o_rsp        = '0;
        o_alloc_slot = '0;
        o_hit_slot   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                o_rsp.free_found = 1'b1;
                o_alloc_slot     = SW'(i);
            end
            if (r_valid[i] && !i_lookup_byte[7] && (r_chan[i] == i_lookup_byte[6:0])) begin
                o_rsp.hit  = 1'b1;
                o_hit_slot = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_req.alloc && o_rsp.free_found) begin
                r_valid[o_alloc_slot] <= 1'b1;
            end
            if (i_req.free) begin
                r_valid[i_free_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.alloc && o_rsp.free_found) begin
            r_chan[o_alloc_slot] <= i_cid;
        end
    end

endmodule

// ----- sv/prdc_deframer.sv -----
`timescale 1ns / 1ps
// Frame parser state machine with the registered result stage.
// Depends on prdc_pkg; drives the channel table requests.
module prdc_deframer #(
    parameter int SLOTS = prdc_pkg::SLOTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_accept,
    input  logic                                   i_cmd,
    input  logic [7:0]                             i_rx_byte,
    input  logic [6:0]                             i_cid,
    input  prdc_pkg::t_cfg                         i_cfg,
    input  prdc_pkg::t_tbl_rsp                     i_rsp,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_alloc_slot,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_hit_slot,
    output prdc_pkg::t_tbl_req                     o_req,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_free_slot,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output prdc_pkg::t_result                      o_result
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_LEN   = 3'd1,
        ST_CHAN  = 3'd2,
        ST_DATA  = 3'd3,
        ST_DRAIN = 3'd4,
        ST_SKIP  = 3'd5
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_bytes_left, n_bytes_left;
    logic [7:0]        r_frame_channel, n_frame_channel;
    logic [7:0]        r_frame_type, n_frame_type;
    logic [SW-1:0]     r_frame_slot, n_frame_slot;
    logic              r_out_valid;
    prdc_pkg::t_result r_result, n_result;
    logic              n_res;
    logic              w_last;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign w_last      = (r_bytes_left == 8'd1);

    always_comb begin
        n_state         = r_state;
        n_bytes_left    = r_bytes_left;
        n_frame_channel = r_frame_channel;
        n_frame_type    = r_frame_type;
        n_frame_slot    = r_frame_slot;
        n_result        = '0;
        n_result.kind   = prdc_pkg::KIND_START;
        n_res           = 1'b0;
        o_req           = '0;
        o_free_slot     = r_frame_slot;
        if (i_accept) begin
            if (i_cmd) begin
                n_res            = 1'b1;
                n_result.channel = {1'b0, i_cid};
                if (i_rsp.free_found) begin
                    o_req.alloc   = 1'b1;
                    n_result.kind = prdc_pkg::KIND_REG;
                    n_result.slot = 2'(i_alloc_slot);
                end else begin
                    n_result.kind = prdc_pkg::KIND_FULL;
                end
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if ((i_rx_byte == i_cfg.reply_type) || (i_rx_byte == i_cfg.write_type)
                                || (i_rx_byte == i_cfg.eof_type)) begin
                            n_frame_type = i_rx_byte;
                            n_state      = ST_LEN;
                        end
                    end
                    ST_LEN: begin
                        n_bytes_left = (i_rx_byte < prdc_pkg::LEN_OVERHEAD) ? 8'd0
                                     : i_rx_byte - prdc_pkg::LEN_OVERHEAD;
                        n_state      = ST_CHAN;
                    end
                    ST_CHAN: begin
                        n_frame_channel = i_rx_byte;
                        if (!i_rsp.hit) begin
                            n_state = (r_bytes_left == 8'd0) ? ST_IDLE : ST_SKIP;
                        end else begin
                            n_frame_slot = i_hit_slot;
                            if (r_bytes_left <= i_cfg.capacity) begin
                                n_res                   = 1'b1;
                                n_result.kind           = prdc_pkg::KIND_START;
                                n_result.slot           = 2'(i_hit_slot);
                                n_result.channel        = i_rx_byte;
                                n_result.frame_type     = r_frame_type;
                                n_result.content_length = r_bytes_left;
                                if (r_bytes_left == 8'd0) begin
                                    n_result.done_res = 1'b1;
                                    o_req.free        = 1'b1;
                                    o_free_slot       = i_hit_slot;
                                    n_state           = ST_IDLE;
                                end else begin
                                    n_state = ST_DATA;
                                end
                            end else begin
                                n_state = ST_DRAIN;
                            end
                        end
                    end
                    ST_DATA, ST_DRAIN: begin
                        n_bytes_left        = r_bytes_left - 8'd1;
                        n_res               = 1'b1;
                        n_result.slot       = 2'(r_frame_slot);
                        n_result.channel    = r_frame_channel;
                        n_result.frame_type = r_frame_type;
                        n_result.done_res   = w_last;
                        if (r_state == ST_DATA) begin
                            n_result.kind      = prdc_pkg::KIND_DATA;
                            n_result.data_byte = i_rx_byte;
                        end else begin
                            n_result.kind  = prdc_pkg::KIND_DRAIN;
                            n_result.error = w_last;
                        end
                        if (w_last) begin
                            o_req.free = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                    ST_SKIP: begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (w_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_bytes_left    <= 8'd0;
            r_frame_channel <= 8'd0;
            r_frame_type    <= 8'd0;
            r_frame_slot    <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_bytes_left    <= n_bytes_left;
            r_frame_channel <= n_frame_channel;
            r_frame_type    <= n_frame_type;
            r_frame_slot    <= n_frame_slot;
            if (n_res) begin
                r_out_valid <= 1'b1;
                r_result    <= n_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- test/tb_packet_rx_deframer_channel_router.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for packet_rx_deframer_channel_router: drives received bytes and
// channel registrations, predicts every result word and checks the master stream against it.
// Depends on prdc_pkg and the packet_rx_deframer_channel_router RTL.
module tb_packet_rx_deframer_channel_router;

    localparam int SLOTS       = prdc_pkg::SLOTS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 120;

    class route_scoreboard;
        typedef enum logic [2:0] {
            RX_WAIT_TYPE,
            RX_LEN,
            RX_CHAN,
            RX_DATA,
            RX_DRAIN,
            RX_SKIP
        } t_rx_phase;

        logic [7:0]        type_reply, type_write, type_eof, capacity;
        t_rx_phase         phase;
        logic [7:0]        left, chan, ftype;
        logic [1:0]        fslot;
        bit                valid[SLOTS];
        logic [6:0]        chan_tab[SLOTS];
        prdc_pkg::t_result expected_words[$];
        int                errors;
        int                checked;

        function new();
            type_reply = 8'd1;
            type_write = 8'd2;
            type_eof   = 8'd3;
            capacity   = 8'd252;
            phase      = RX_WAIT_TYPE;
            left       = '0;
            chan       = '0;
            ftype      = '0;
            fslot      = '0;
            for (int i = 0; i < SLOTS; i++) begin
                valid[i]    = 1'b0;
                chan_tab[i] = '0;
            end
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(prdc_pkg::t_reg_idx idx, logic [7:0] value);
            case (idx)
                prdc_pkg::REG_REPLY_TYPE: type_reply = value;
                prdc_pkg::REG_WRITE_TYPE: type_write = value;
                prdc_pkg::REG_EOF_TYPE:   type_eof = value;
                prdc_pkg::REG_CAPACITY:   capacity = value;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int pick_valid_channel();
            int idx[$];
            int i;
            for (i = 0; i < SLOTS; i++) begin
                if (valid[i]) idx.push_back(i);
            end
            if (idx.size() == 0) return -1;
            return int'(chan_tab[idx[$urandom_range(0, idx.size() - 1)]]);
        endfunction

        function void note_word(bit cmd, logic [7:0] b, logic [6:0] cid);
            prdc_pkg::t_result r;
            int                hit;
            int                i;
            bit                is_data;
            r   = '0;
            hit = -1;
            if (cmd) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (!valid[i] && hit < 0) hit = i;
                end
                r.channel = {1'b0, cid};
                if (hit >= 0) begin
                    valid[hit]    = 1'b1;
                    chan_tab[hit] = cid;
                    r.kind        = prdc_pkg::KIND_REG;
                    r.slot        = hit[1:0];
                end else begin
                    r.kind = prdc_pkg::KIND_FULL;
                end
                expected_words.push_back(r);
                return;
            end
            case (phase)
                RX_WAIT_TYPE: begin
                    if (b == type_reply || b == type_write || b == type_eof) begin
                        ftype = b;
                        phase = RX_LEN;
                    end
                end
                RX_LEN: begin
                    left  = (b < prdc_pkg::LEN_OVERHEAD) ? 8'd0 : b - prdc_pkg::LEN_OVERHEAD;
                    phase = RX_CHAN;
                end
                RX_CHAN: begin
                    chan = b;
                    for (i = 0; i < SLOTS; i++) begin
                        if (hit < 0 && valid[i] && {1'b0, chan_tab[i]} == b) hit = i;
                    end
                    if (hit < 0) begin
                        phase = (left == 8'd0) ? RX_WAIT_TYPE : RX_SKIP;
                    end else begin
                        fslot = hit[1:0];
                        if (left <= capacity) begin
                            r.kind           = prdc_pkg::KIND_START;
                            r.slot           = fslot;
                            r.channel        = chan;
                            r.frame_type     = ftype;
                            r.content_length = left;
                            if (left == 8'd0) begin
                                valid[hit] = 1'b0;
                                r.done_res = 1'b1;
                                phase      = RX_WAIT_TYPE;
                            end else begin
                                phase = RX_DATA;
                            end
                            expected_words.push_back(r);
                        end else begin
                            phase = RX_DRAIN;
                        end
                    end
                end
                RX_DATA, RX_DRAIN: begin
                    is_data      = (phase == RX_DATA);
                    left         = left - 8'd1;
                    r.kind       = is_data ? prdc_pkg::KIND_DATA : prdc_pkg::KIND_DRAIN;
                    r.slot       = fslot;
                    r.channel    = chan;
                    r.frame_type = ftype;
                    r.data_byte  = is_data ? b : 8'd0;
                    r.done_res   = (left == 8'd0);
                    r.error      = r.done_res && !is_data;
                    if (r.done_res) begin
                        valid[fslot] = 1'b0;
                        phase        = RX_WAIT_TYPE;
                    end
                    expected_words.push_back(r);
                end
                RX_SKIP: begin
                    left = left - 8'd1;
                    if (left == 8'd0) phase = RX_WAIT_TYPE;
                end
                default: phase = RX_WAIT_TYPE;
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < 100) $display("MISMATCH at result word %0d: %s", checked, msg);
            errors++;
        endtask

        task check_word(prdc_pkg::t_result got);
            prdc_pkg::t_result want;
            checked++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word, kind %0d", got.kind));
                return;
            end
            want = expected_words.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.channel !== want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d", got.channel,
                                          want.channel));
            if (got.frame_type !== want.frame_type)
                report_mismatch($sformatf("frame_type %0d, expected %0d", got.frame_type,
                                          want.frame_type));
            if (got.content_length !== want.content_length)
                report_mismatch($sformatf("content_length %0d, expected %0d",
                                          got.content_length, want.content_length));
            if (got.data_byte !== want.data_byte)
                report_mismatch($sformatf("data_byte %0d, expected %0d", got.data_byte,
                                          want.data_byte));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res %0b, expected %0b", got.done_res,
                                          want.done_res));
            if (got.error !== want.error)
                report_mismatch($sformatf("error %0b, expected %0b", got.error, want.error));
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [15:0]                     i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [39:0]                     o_m_tdata;
    logic [3:0]                      o_m_tuser;
    logic                            o_m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [prdc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    route_scoreboard sb;
    bit              no_idle;
    bit              hold_go;

    packet_rx_deframer_channel_router dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic apb_write(input prdc_pkg::t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(input bit cmd, input logic [7:0] b, input logic [6:0] cid);
        while (!no_idle && $urandom_range(0, 99) < 14) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {1'b0, 15'($urandom)};
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, cid, b};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_word(cmd, b, cid);
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [7:0] ftype, input logic [7:0] flen,
                               input logic [7:0] fchan);
        send_word(1'b0, ftype, 7'($urandom));
        send_word(1'b0, flen, 7'($urandom));
        send_word(1'b0, fchan, 7'($urandom));
    endtask

    task automatic run_directed();
        send_word(1'b1, 8'h00, 7'd0);
        send_word(1'b1, 8'hFF, 7'd127);
        send_word(1'b1, 8'h5A, 7'd5);
        send_word(1'b1, 8'hA5, 7'd5);
        send_word(1'b1, 8'h00, 7'd9);
        send_word(1'b0, 8'hFF, 7'h7F);
        send_header(8'd1, 8'd0, 8'd0);
        send_header(8'd3, 8'd5, 8'd127);
        send_word(1'b0, 8'h00, 7'h00);
        send_word(1'b0, 8'hFF, 7'h7F);
        send_header(8'd2, 8'd3, 8'hFF);
        send_header(8'd2, 8'd4, 8'd200);
        send_word(1'b0, 8'hAA, 7'h55);
        send_header(8'd1, 8'd8, 8'd5);
        send_word(1'b0, 8'h11, 7'h00);
        send_word(1'b0, 8'h22, 7'h00);
        send_word(1'b1, 8'h33, 7'd77);
        send_word(1'b0, 8'h44, 7'h00);
        send_word(1'b0, 8'h55, 7'h00);
        send_word(1'b0, 8'h66, 7'h00);
    endtask

    task automatic run_random(input int n_items);
        int         sent;
        int         r;
        int         ch_pick;
        int         n_body;
        int         k;
        logic [7:0] ftype;
        logic [7:0] flen;
        logic [7:0] fchan;
        sent = 0;
        while (sent < n_items) begin
            r       = $urandom_range(0, 99);
            ch_pick = sb.pick_valid_channel();
            if (r < 20) begin
                if (ch_pick >= 0 && $urandom_range(0, 3) == 0)
                    send_word(1'b1, 8'($urandom), ch_pick[6:0]);
                else
                    send_word(1'b1, 8'($urandom), 7'($urandom));
                sent++;
            end else if (r < 26) begin
                send_word(1'b0, 8'($urandom), 7'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0:       ftype = 8'($urandom);
                    1, 2, 3: ftype = sb.type_reply;
                    4, 5, 6: ftype = sb.type_write;
                    default: ftype = sb.type_eof;
                endcase
                if ($urandom_range(0, 24) == 0) flen = 8'($urandom);
                else flen = 8'($urandom_range(0, 12));
                if (ch_pick >= 0 && $urandom_range(0, 9) < 8) fchan = 8'(ch_pick);
                else if ($urandom_range(0, 1) == 1) fchan = 8'($urandom_range(128, 255));
                else fchan = 8'($urandom_range(0, 127));
                n_body = (flen < 8'd3) ? 0 : int'(flen) - 3;
                if ($urandom_range(0, 19) == 0) n_body = $urandom_range(0, n_body);
                send_header(ftype, flen, fchan);
                for (k = 0; k < n_body; k++) send_word(1'b0, 8'($urandom), 7'($urandom));
                sent += 3 + n_body;
            end
        end
    endtask

    initial begin : receiver
        int k;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                i_m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge i_clk);
                hold_go = 1'b0;
            end
            i_m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge i_clk) begin : monitor
        prdc_pkg::t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got                = '0;
            got.slot           = o_m_tdata[1:0];
            got.channel        = o_m_tdata[9:2];
            got.frame_type     = o_m_tdata[17:10];
            got.content_length = o_m_tdata[25:18];
            got.data_byte      = o_m_tdata[33:26];
            got.kind           = prdc_pkg::t_kind'(o_m_tuser[2:0]);
            got.error          = o_m_tuser[3];
            got.done_res       = o_m_tlast;
            sb.check_word(got);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("packet_rx_deframer_channel_router test failed");
        $finish;
    end

    initial begin : stimulus
        int p;
        int k;
        sb         = new();
        no_idle    = 1'b0;
        hold_go    = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (p = 0; p < 5; p++) begin
            if (p > 0) begin
                while (sb.pending() != 0) @(negedge i_clk);
                repeat (4) @(negedge i_clk);
            end
            case (p)
                0: begin
                    apb_write(prdc_pkg::REG_REPLY_TYPE, 8'd1);
                    apb_write(prdc_pkg::REG_WRITE_TYPE, 8'd2);
                    apb_write(prdc_pkg::REG_EOF_TYPE, 8'd3);
                    apb_write(prdc_pkg::REG_CAPACITY, 8'd4);
                end
                1: begin
                    apb_write(prdc_pkg::REG_REPLY_TYPE, 8'd0);
                    apb_write(prdc_pkg::REG_WRITE_TYPE, 8'd255);
                    apb_write(prdc_pkg::REG_EOF_TYPE, 8'd128);
                    apb_write(prdc_pkg::REG_CAPACITY, 8'd0);
                end
                2: begin
                    apb_write(prdc_pkg::REG_REPLY_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_WRITE_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_EOF_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_CAPACITY, 8'd252);
                end
                3: begin
                    apb_write(prdc_pkg::REG_REPLY_TYPE, 8'd7);
                    apb_write(prdc_pkg::REG_WRITE_TYPE, 8'd7);
                    apb_write(prdc_pkg::REG_EOF_TYPE, 8'd7);
                    apb_write(prdc_pkg::REG_CAPACITY, 8'd255);
                end
                default: begin
                    apb_write(prdc_pkg::REG_REPLY_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_WRITE_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_EOF_TYPE, 8'($urandom));
                    apb_write(prdc_pkg::REG_CAPACITY, 8'($urandom_range(0, 252)));
                end
            endcase
            no_idle = (p == 3);
            if (p == 0) run_directed();
            if (p == 2) begin
                hold_go = 1'b1;
                for (k = 0; k < 6; k++) send_word(1'b1, 8'($urandom), 7'($urandom));
            end
            run_random(135);
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("packet_rx_deframer_channel_router test passed");
        end else begin
            $display("packet_rx_deframer_channel_router test failed");
        end
        $finish;
    end

endmodule

// ----- packet_rx_deframer_channel_router.f -----
sv/prdc_pkg.sv
sv/prdc_apb_regs.sv
sv/prdc_chan_table.sv
sv/prdc_deframer.sv
sv/packet_rx_deframer_channel_router.sv
test/tb_packet_rx_deframer_channel_router.sv
